### rtl/htd_pkg.sv
// shared types and constants of the huffman tree decoder
`default_nettype none

package htd_pkg;

    localparam int IDX_W   = 9;
    localparam int CHILD_W = 10;
    localparam int SYM_W   = 8;
    localparam int BYTE_W  = 8;

    // request type codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_DATA = 1'b1;

    // one symbol beat handed to the output stage
    typedef struct packed {
        logic             valid;
        logic [SYM_W-1:0] symbol;
        logic             last;
    } push_t;

endpackage

`default_nettype wire

### rtl/htd_if.sv
// channel interfaces: request, result and root register write
`default_nettype none

interface htd_req_if;
    import htd_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic [IDX_W-1:0]          node_index;
    logic signed [CHILD_W-1:0] left_child;
    logic signed [CHILD_W-1:0] right_child;
    logic [SYM_W-1:0]          leaf_symbol;
    logic [BYTE_W-1:0]         data_byte;

    modport source (
        output valid, req_type, node_index, left_child, right_child, leaf_symbol,
               data_byte,
        input  ready
    );
    modport sink (
        input  valid, req_type, node_index, left_child, right_child, leaf_symbol,
               data_byte,
        output ready
    );
endinterface

interface htd_res_if;
    import htd_pkg::*;
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;
    logic             last;

    modport source (output valid, symbol, last, input ready);
    modport sink (input valid, symbol, last, output ready);
endinterface

interface htd_cfg_if;
    import htd_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] root_index;

    modport source (output valid, root_index, input ready);
    modport sink (input valid, root_index, output ready);
endinterface

`default_nettype wire

### rtl/huffman_tree_decoder.sv
// top level: node memory, tree walk sequencer and output stage
//
// Huffman tree walk decoder. A load beat (req_type 0) writes one node into a
// single-port node memory. A data beat (req_type 1) walks the tree with the
// eight bits of data_byte, most significant first; every leaf reached gives
// one result beat, and the final one of the byte has last set. The request
// side is busy while a byte is decoded. Each code bit reads the chosen child
// from the registered node memory, then tests it as a leaf; when the chosen
// child is absent or the position lies outside the table, the bit only steps
// back to the root. After the walk returned to the root the current node is
// fetched again first, before the next bit. A closing state hands over the
// last symbol of the byte, if there is one. Stalls on the result side hold
// the walk. Writing root_index restarts the walk and is taken at any cycle
// while the block is idle.
`default_nettype none

module huffman_tree_decoder
    import htd_pkg::*;
#(
    parameter int MAX_NODES = 512
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    htd_req_if.sink   req,
    htd_res_if.source res,
    htd_cfg_if.sink   cfg
);

    localparam int AW = $clog2(MAX_NODES);
    localparam logic [IDX_W+1:0] NODE_LIM = (IDX_W+2)'(MAX_NODES);

    typedef struct packed {
        logic [CHILD_W-1:0] left;
        logic [CHILD_W-1:0] right;
        logic [SYM_W-1:0]   symbol;
    } node_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_STEP  = 5'b00010,
        ST_FILL  = 5'b00100,
        ST_CHILD = 5'b01000,
        ST_FLUSH = 5'b10000
    } state_t;

    function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
        logic [AW+IDX_W-1:0] ext;
        ext = {{AW{1'b0}}, idx};
        return ext[AW-1:0];
    endfunction

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    root_reg, root_next;
    logic [IDX_W-1:0]    pos_reg, pos_next;
    logic [2:0]          cnt_reg, cnt_next;
    logic                cache_vld_reg, cache_vld_next;
    logic                pend_vld_reg, pend_vld_next;
    logic [BYTE_W-1:0]   byte_reg, byte_next;
    node_t               cache_reg, cache_next;
    logic [IDX_W-1:0]    child_reg, child_next;
    logic [SYM_W-1:0]    pend_sym_reg, pend_sym_next;

    node_t               mem [MAX_NODES];
    node_t               rd_data_reg;
    logic                mem_we;
    logic                mem_re;
    logic [IDX_W-1:0]    mem_idx;
    node_t               mem_wdata;

    push_t               push;
    logic                free;

    logic                req_fire;
    logic                cfg_fire;
    logic                pos_oob;
    logic [CHILD_W-1:0]  chosen;
    logic                child_absent;
    logic                rd_leaf;

    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign cfg_fire  = cfg.valid && cfg.ready;

    // walk decode of the current node
    assign pos_oob      = {2'b00, pos_reg} >= NODE_LIM;
    assign chosen       = byte_reg[BYTE_W-1] ? cache_reg.right : cache_reg.left;
    assign child_absent = chosen[CHILD_W-1] || ({1'b0, chosen} >= NODE_LIM);
    assign rd_leaf      = rd_data_reg.left[CHILD_W-1] && rd_data_reg.right[CHILD_W-1];

    assign mem_wdata = '{left:   unsigned'(req.left_child),
                         right:  unsigned'(req.right_child),
                         symbol: req.leaf_symbol};

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        root_next      = root_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        cache_vld_next = cache_vld_reg;
        pend_vld_next  = pend_vld_reg;
        byte_next      = byte_reg;
        cache_next     = cache_reg;
        child_next     = child_reg;
        pend_sym_next  = pend_sym_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_idx        = pos_reg;
        push.valid     = 1'b0;
        push.symbol    = pend_sym_reg;
        push.last      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.req_type == REQ_LOAD)
                    begin
                        mem_idx = req.node_index;
                        if ({2'b00, req.node_index} < NODE_LIM)
                        begin
                            mem_we         = 1'b1;
                            cache_vld_next = 1'b0;
                        end
                    end
                    else
                    begin
                        byte_next  = req.data_byte;
                        cnt_next   = '0;
                        state_next = ST_STEP;
                    end
                end
            end

            ST_STEP:
            begin
                if (pos_oob || (cache_vld_reg && child_absent))
                begin
                    // no node to step from or no child: back to the root
                    pos_next       = root_reg;
                    cache_vld_next = 1'b0;
                    byte_next      = byte_reg << 1;
                    cnt_next       = cnt_reg + 3'd1;
                    state_next     = (cnt_reg == 3'd7) ? ST_FLUSH : ST_STEP;
                end
                else if (!cache_vld_reg)
                begin
                    mem_re     = 1'b1;
                    mem_idx    = pos_reg;
                    state_next = ST_FILL;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_idx    = chosen[IDX_W-1:0];
                    child_next = chosen[IDX_W-1:0];
                    state_next = ST_CHILD;
                end
            end

            ST_FILL:
            begin
                cache_next     = rd_data_reg;
                cache_vld_next = 1'b1;
                state_next     = ST_STEP;
            end

            ST_CHILD:
            begin
                if (!rd_leaf)
                begin
                    pos_next       = child_reg;
                    cache_next     = rd_data_reg;
                    cache_vld_next = 1'b1;
                    byte_next      = byte_reg << 1;
                    cnt_next       = cnt_reg + 3'd1;
                    state_next     = (cnt_reg == 3'd7) ? ST_FLUSH : ST_STEP;
                end
                else if (!pend_vld_reg || free)
                begin
                    // leaf: earlier symbol goes out, this one is held back
                    push.valid     = pend_vld_reg;
                    pend_sym_next  = rd_data_reg.symbol;
                    pend_vld_next  = 1'b1;
                    pos_next       = root_reg;
                    cache_vld_next = 1'b0;
                    byte_next      = byte_reg << 1;
                    cnt_next       = cnt_reg + 3'd1;
                    state_next     = (cnt_reg == 3'd7) ? ST_FLUSH : ST_STEP;
                end
            end

            ST_FLUSH:
            begin
                if (!pend_vld_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (free)
                begin
                    push.valid    = 1'b1;
                    push.last     = 1'b1;
                    pend_vld_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // root register write restarts the walk
        if (cfg_fire)
        begin
            root_next      = cfg.root_index;
            pos_next       = cfg.root_index;
            cache_vld_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            root_reg      <= '0;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            cache_vld_reg <= 1'b0;
            pend_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            root_reg      <= root_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            cache_vld_reg <= cache_vld_next;
            pend_vld_reg  <= pend_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        cache_reg    <= cache_next;
        child_reg    <= child_next;
        pend_sym_reg <= pend_sym_next;
    end

    // node memory, one port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[to_addr(mem_idx)] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[to_addr(mem_idx)];
        end
    end

    htd_out_stage u_out_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .free  (free),
        .res   (res)
    );

endmodule

`default_nettype wire

### rtl/htd_out_stage.sv
// output register that holds one symbol beat until the sink takes it
`default_nettype none

module htd_out_stage
    import htd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire push_t push,
    output logic       free,
    htd_res_if.source  res
);

    logic             vld_reg;
    logic [SYM_W-1:0] sym_reg;
    logic             last_reg;

    // room for a new beat when empty or when the held beat leaves now
    assign free = !vld_reg || res.ready;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (push.valid)
        begin
            vld_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            vld_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            sym_reg  <= push.symbol;
            last_reg <= push.last;
        end
    end

    assign res.valid  = vld_reg;
    assign res.symbol = sym_reg;
    assign res.last   = last_reg;

endmodule

`default_nettype wire

### rtl/htd_checker.sv
// port level checks of the huffman tree decoder and their binding
`default_nettype none

module htd_checker
    import htd_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             req_valid,
    input wire logic             req_ready,
    input wire logic             req_type,
    input wire logic             res_valid,
    input wire logic             res_ready,
    input wire logic [SYM_W-1:0] res_symbol,
    input wire logic             res_last
);

    // a stalled result beat holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_symbol) && $stable(res_last))
        else $error("result beat changed while stalled");

    // a data byte keeps the request side busy for its walk
    a_data_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_type == REQ_DATA |=> !req_ready)
        else $error("request taken during a byte walk");

    // a node load never produces a result beat
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_type == REQ_LOAD && !res_valid |=> !res_valid)
        else $error("result beat after a node load");

    // a symbol that is not the last of its byte means the byte is still in work
    a_mid_byte: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_last |-> !req_ready)
        else $error("idle while a byte still owes its last symbol");

endmodule

bind huffman_tree_decoder htd_checker u_htd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .req_type   (req.req_type),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .res_symbol (res.symbol),
    .res_last   (res.last)
);

`default_nettype wire

### tb/tb_top.sv
// testbench for the huffman tree walk decoder: tree loads, byte decoding, root changes
`timescale 1ns / 1ps

module tb_top;
    import htd_pkg::*;

    localparam int TABLE_DEPTH = 512;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PHASES = 4;
    localparam int PHASE_ITEMS = 28;

    // child codes with the sign bit set mean no child
    localparam logic [CHILD_W-1:0] CHILD_NONE     = 10'h3FF;
    localparam logic [CHILD_W-1:0] CHILD_NONE_MIN = 10'h200;

    typedef struct packed {
        logic                req_type;
        logic [IDX_W-1:0]    node_index;
        logic [CHILD_W-1:0]  left_child;
        logic [CHILD_W-1:0]  right_child;
        logic [SYM_W-1:0]    leaf_symbol;
        logic [BYTE_W-1:0]   data_byte;
    } request_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
    } sym_beat_t;

    typedef enum int {RX_FREE, RX_HALF, RX_SPARSE, RX_HICCUP} rx_pattern_t;

    // tree walk predictor and symbol scoreboard
    class decode_checker;
        logic [CHILD_W-1:0] left_tab [TABLE_DEPTH];
        logic [CHILD_W-1:0] right_tab [TABLE_DEPTH];
        logic [SYM_W-1:0]   sym_tab [TABLE_DEPTH];
        logic [IDX_W-1:0]   root_idx;
        logic [IDX_W-1:0]   walk_pos;
        sym_beat_t          pending_syms[$];
        int                 failures;
        int                 symbols_checked;

        function new();
            root_idx = '0;
            walk_pos = '0;
            failures = 0;
            symbols_checked = 0;
        endfunction

        function void set_root(logic [IDX_W-1:0] r);
            root_idx = r;
            walk_pos = r;
        endfunction

        // loads update the tables, data bytes walk the tree bit by bit
        function void note_request(request_t rq);
            logic [CHILD_W-1:0] child;
            sym_beat_t          beat;
            int                 emitted;
            if (rq.req_type == REQ_LOAD)
            begin
                left_tab[rq.node_index]  = rq.left_child;
                right_tab[rq.node_index] = rq.right_child;
                sym_tab[rq.node_index]   = rq.leaf_symbol;
                return;
            end
            emitted = 0;
            for (int b = BYTE_W - 1; b >= 0; b--)
            begin
                child = rq.data_byte[b] ? right_tab[walk_pos] : left_tab[walk_pos];
                // a non-negative 10-bit child always fits the 512-entry table
                if (child[CHILD_W-1])
                    walk_pos = root_idx;
                else if (left_tab[child[IDX_W-1:0]][CHILD_W-1] &&
                         right_tab[child[IDX_W-1:0]][CHILD_W-1])
                begin
                    beat.symbol = sym_tab[child[IDX_W-1:0]];
                    beat.last = 1'b0;
                    pending_syms.insert(pending_syms.size(), beat);
                    emitted++;
                    walk_pos = root_idx;
                end
                else
                    walk_pos = child[IDX_W-1:0];
            end
            if (emitted > 0)
                pending_syms[pending_syms.size() - 1].last = 1'b1;
        endfunction

        function void check_symbol(logic [SYM_W-1:0] sym, logic last);
            sym_beat_t want;
            if (pending_syms.size() == 0)
            begin
                $error("unexpected symbol beat: symbol %02h last %0b", sym, last);
                failures++;
                return;
            end
            want = pending_syms.pop_front();
            symbols_checked++;
            if (sym !== want.symbol)
            begin
                $error("symbol mismatch: expected %02h, got %02h", want.symbol, sym);
                failures++;
            end
            if (last !== want.last)
            begin
                $error("last mismatch: expected %0b, got %0b", want.last, last);
                failures++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    htd_req_if req ();
    htd_res_if res ();
    htd_cfg_if cfg ();

    huffman_tree_decoder #(
        .MAX_NODES (TABLE_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .res   (res),
        .cfg   (cfg)
    );

    decode_checker chk;
    bit            hold_ask;
    int            burst_left;
    int            loads_sent;
    int            bytes_sent;
    int            root_writes;
    int unsigned   cycle_count;
    bit            node_written [TABLE_DEPTH];
    int            written_nodes[$];
    bit            tree_used [TABLE_DEPTH];

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("tb_top NOT OK");
        $finish;
    end

    // result monitor
    always @(posedge clk)
        if (rst_n === 1'b1 && res.valid === 1'b1 && res.ready === 1'b1)
            chk.check_symbol(res.symbol, res.last);

    // result receiver: changing stall patterns plus one long hold-off on request
    initial
    begin
        rx_pattern_t pattern;
        int          run_left;
        res.ready <= 1'b0;
        pattern = RX_FREE;
        run_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_ask)
            begin
                hold_ask = 1'b0;
                res.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (run_left == 0)
                begin
                    pattern = rx_pattern_t'($urandom_range(0, 3));
                    run_left = $urandom_range(10, 60);
                end
                run_left--;
                case (pattern)
                    RX_FREE:   res.ready <= 1'b1;
                    RX_HALF:   res.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: res.ready <= ($urandom_range(0, 3) == 0);
                    default:   res.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // offer one request beat, with a random gap at the start of each burst
    task automatic send_request(input request_t rq);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req.valid       <= 1'b1;
        req.req_type    <= rq.req_type;
        req.node_index  <= rq.node_index;
        req.left_child  <= rq.left_child;
        req.right_child <= rq.right_child;
        req.leaf_symbol <= rq.leaf_symbol;
        req.data_byte   <= rq.data_byte;
        do @(posedge clk); while (req.ready !== 1'b1);
        chk.note_request(rq);
    endtask

    task automatic send_load(input int idx, input logic [CHILD_W-1:0] lc,
                             input logic [CHILD_W-1:0] rc, input logic [SYM_W-1:0] sym);
        request_t rq;
        rq.req_type    = REQ_LOAD;
        rq.node_index  = IDX_W'(idx);
        rq.left_child  = lc;
        rq.right_child = rc;
        rq.leaf_symbol = sym;
        rq.data_byte   = BYTE_W'($urandom);
        send_request(rq);
        loads_sent++;
        if (!node_written[idx])
        begin
            node_written[idx] = 1'b1;
            written_nodes.insert(written_nodes.size(), idx);
        end
    endtask

    // data beats carry random junk in the node fields
    task automatic send_data(input logic [BYTE_W-1:0] code_bits);
        request_t rq;
        rq.req_type    = REQ_DATA;
        rq.node_index  = IDX_W'($urandom);
        rq.left_child  = CHILD_W'($urandom);
        rq.right_child = CHILD_W'($urandom);
        rq.leaf_symbol = SYM_W'($urandom);
        rq.data_byte   = code_bits;
        send_request(rq);
        bytes_sent++;
    endtask

    // stop offering until every symbol is back and the walk has finished
    task automatic wait_drained();
        req.valid <= 1'b0;
        burst_left = 0;
        while (chk.pending_syms.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_root(input logic [IDX_W-1:0] r);
        cfg.valid      <= 1'b1;
        cfg.root_index <= r;
        do @(posedge clk); while (cfg.ready !== 1'b1);
        cfg.valid <= 1'b0;
        chk.set_root(r);
        root_writes++;
    endtask

    function automatic logic [CHILD_W-1:0] absent_child();
        return {1'b1, IDX_W'($urandom)};
    endfunction

    // children only point at nodes already written, so no walk reads an empty entry
    function automatic logic [CHILD_W-1:0] any_child();
        if ($urandom_range(0, 1) == 0)
            return absent_child();
        return CHILD_W'(written_nodes[$urandom_range(0, written_nodes.size() - 1)]);
    endfunction

    function automatic int fresh_index();
        int idx;
        do idx = $urandom_range(0, TABLE_DEPTH - 1); while (tree_used[idx]);
        tree_used[idx] = 1'b1;
        return idx;
    endfunction

    // full binary code tree at scattered table positions, leaves written first
    task automatic build_tree(input int leaves, output logic [IDX_W-1:0] tree_root);
        int subtrees[$];
        int idx;
        int pos;
        int lo;
        int hi;
        tree_used = '{default: 1'b0};
        for (int i = 0; i < leaves; i++)
        begin
            idx = fresh_index();
            send_load(idx, absent_child(), absent_child(), SYM_W'($urandom));
            subtrees.insert(subtrees.size(), idx);
        end
        while (subtrees.size() > 1)
        begin
            pos = $urandom_range(0, subtrees.size() - 1);
            lo = subtrees[pos];
            subtrees.delete(pos);
            pos = $urandom_range(0, subtrees.size() - 1);
            hi = subtrees[pos];
            subtrees.delete(pos);
            idx = fresh_index();
            send_load(idx, CHILD_W'(lo), CHILD_W'(hi), SYM_W'($urandom));
            subtrees.insert(subtrees.size(), idx);
        end
        tree_root = IDX_W'(subtrees[0]);
    endtask

    // main sequence
    initial
    begin
        logic [IDX_W-1:0] tree_root;
        chk = new();
        rst_n           <= 1'b0;
        req.valid       <= 1'b0;
        req.req_type    <= REQ_LOAD;
        req.node_index  <= '0;
        req.left_child  <= '0;
        req.right_child <= '0;
        req.leaf_symbol <= '0;
        req.data_byte   <= '0;
        cfg.valid       <= 1'b0;
        cfg.root_index  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed tree: two leaves, a node with one missing child, a self loop
        send_load(300, CHILD_NONE, CHILD_NONE_MIN, 8'h00);
        send_load(200, CHILD_NONE_MIN, CHILD_NONE, 8'hFF);
        send_load(5, CHILD_NONE, 10'd200, 8'h33);
        send_load(511, 10'd300, 10'd5, 8'hC4);
        send_load(0, 10'd0, 10'd511, 8'h5A);
        wait_drained();
        write_root(511);
        send_data(8'h00);
        send_data(8'hFF);
        send_data(8'h55);
        send_data(8'hAA);
        send_data(8'h80);
        // walk left halfway at node 5, then a load must not disturb it
        send_data(8'h7F);
        send_load(200, 10'h2AA, 10'h355, 8'h81);
        send_data(8'hFF);

        // root at index zero with a self loop
        wait_drained();
        write_root(0);
        send_data(8'h01);
        send_data(8'h00);

        // root that is itself a leaf never emits
        wait_drained();
        write_root(300);
        send_data(8'hC3);

        // random trees with random byte streams and some rewiring noise
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            build_tree($urandom_range(2, 10), tree_root);
            wait_drained();
            write_root(tree_root);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 1 && n == 4)
                begin
                    hold_ask = 1'b1;
                    burst_left = PHASE_ITEMS;
                end
                if (phase == 2 && n == PHASE_ITEMS / 2)
                    wait_drained();
                if ($urandom_range(0, 99) < 15)
                    send_load($urandom_range(0, TABLE_DEPTH - 1), any_child(), any_child(),
                              SYM_W'($urandom));
                else
                    send_data(BYTE_W'($urandom));
            end
        end

        wait_drained();
        $display("covered %0d node loads and %0d data bytes under %0d root settings",
                 loads_sent, bytes_sent, root_writes);
        $display("%0d symbols checked in %0d cycles, %0d failures",
                 chk.symbols_checked, cycle_count, chk.failures);
        if (chk.failures == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
